// ----- sv/prcm_pkg.sv -----
// Package for the peak/RMS/crest level meter.
// Holds fixed-point constants shared by the core and its checker.
package prcm_pkg;
  localparam int MAX_SAMPLES_DEF = 4096;
  localparam int SUM_W           = 42;
  localparam int CREST_MAX       = 16384;
  localparam int DB_FLOOR        = -46080;
  localparam int DB_K            = 394566;  // 20*log10(2) in Q16
  localparam int LEVEL_MAX       = 32768;
endpackage

// ----- sv/peak_rms_crest_meter_core.sv -----
// Peak/RMS/crest-factor audio meter core.
// Depends on prcm_pkg for fixed-point constants.
//
// Usage: signed Q1.15 samples enter on the in_ channel, one per transfer, with
// in_frame_end marking the last sample of a frame. Non-final samples are taken
// one per cycle while idle. The final sample starts a per-frame computation on
// one shared subtractor and one shared multiplier under a small sequencer:
//   mean square (42-step restoring divide), square root (21 steps),
//   crest ratio (42-step divide), log2 (16 squaring steps), dB scale (1 step).
// A frame end therefore holds in_stall high until the result is registered on
// the out_ channel (an RMS of zero skips the crest, log2 and dB steps, a crest
// ratio below one skips log2 and dB). If the receiver stalls, the result holds
// in the output register while the core keeps taking samples; only when the
// next frame's result is ready does in_stall stay high until the earlier
// transfer completes. Accumulation for the next frame begins as soon as the
// sequencer returns to idle. Frames longer than MAX_SAMPLES raise overflow; the
// extra samples still count toward the peak but not toward the mean. Reset
// clears the accumulators, the sequencer and out_valid.
module peak_rms_crest_meter_core #(
  parameter int MAX_SAMPLES = prcm_pkg::MAX_SAMPLES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_sample,
  input  logic               in_frame_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_rms_level,
  output logic [15:0]        out_peak_level,
  output logic [14:0]        out_crest_ratio,
  output logic signed [16:0] out_crest_decibels,
  output logic [15:0]        out_transient_density,
  output logic               out_overflow
);
  import prcm_pkg::*;

  localparam int CW = $clog2(MAX_SAMPLES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SQRT = 3'd2;
  localparam logic [2:0] S_CDIV = 3'd3;
  localparam logic [2:0] S_LOG  = 3'd4;
  localparam logic [2:0] S_DB   = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [15:0]      peak_r, peak_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             ovf_r, ovf_nxt;

  // Work registers of the frame-end computation.
  logic [15:0]      wpeak_r, wpeak_nxt;
  logic             wovf_r, wovf_nxt;
  logic [SUM_W-1:0] q_r, q_nxt;
  logic [23:0]      rem_r, rem_nxt;
  logic [23:0]      dvs_r, dvs_nxt;
  logic [20:0]      root_r, root_nxt;
  logic [15:0]      rms_r, rms_nxt;
  logic [14:0]      crest_r, crest_nxt;
  logic [30:0]      x_r, x_nxt;
  logic [15:0]      frac_r, frac_nxt;
  logic [3:0]       e_r, e_nxt;
  logic signed [16:0] db_r, db_nxt;
  logic [5:0]       iter_r, iter_nxt;

  logic             out_valid_r;
  logic [15:0]      o_rms_r, o_peak_r, o_dens_r;
  logic [14:0]      o_crest_r;
  logic signed [16:0] o_db_r;
  logic             o_ovf_r;

  logic             accept;
  logic [15:0]      mag;
  logic [31:0]      sq;
  logic [SUM_W:0]   sum_add;

  // Shared subtractor.
  logic [23:0]      sub_a, sub_b;
  logic [24:0]      sub_d;
  logic             sub_ge;
  // Shared multiplier.
  logic [30:0]      mul_a, mul_b;
  logic [61:0]      mul_p;

  logic [31:0]      sq_x;
  logic [18:0]      log_l;
  logic [37:0]      db_round;
  logic [3:0]       e_find;
  logic             out_load;

  assign accept  = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign mag     = in_sample[15] ? 16'(-in_sample) : 16'(in_sample);
  assign sq      = 32'(mag) * 32'(mag);
  assign sum_add = {1'b0, sum_r} + (SUM_W + 1)'(sq);

  assign sub_d   = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge  = !sub_d[24];
  assign mul_p   = 62'(mul_a) * 62'(mul_b);

  assign sq_x     = mul_p[61:30];
  assign log_l    = {3'(e_r - 4'd8), frac_r};
  assign db_round = mul_p[37:0] + 38'(1 << 23);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    e_find = 4'd8;
    for (int i = 8; i < 15; i++) begin
      if (crest_r[i]) e_find = 4'(i);
    end
  end

  always_comb begin
    sub_a = '0;
    sub_b = '0;
    mul_a = x_r;
    mul_b = x_r;
    case (state_r)
      S_DIV, S_CDIV: begin
        sub_a = {rem_r[22:0], q_r[SUM_W-1]};
        sub_b = dvs_r;
      end
      S_SQRT: begin
        sub_a = {rem_r[21:0], q_r[SUM_W-1:SUM_W-2]};
        sub_b = {1'b0, root_r, 2'b01};
      end
      S_DB: begin
        mul_a = 31'(log_l);
        mul_b = 31'(DB_K);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    peak_nxt  = peak_r;
    sum_nxt   = sum_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    wpeak_nxt = wpeak_r;
    wovf_nxt  = wovf_r;
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    root_nxt  = root_r;
    rms_nxt   = rms_r;
    crest_nxt = crest_r;
    x_nxt     = x_r;
    frac_nxt  = frac_r;
    e_nxt     = e_r;
    db_nxt    = db_r;
    iter_nxt  = iter_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (mag > peak_r) peak_nxt = mag;
          if (count_r >= CW'(MAX_SAMPLES)) begin
            ovf_nxt = 1'b1;
          end else begin
            sum_nxt   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
            count_nxt = count_r + CW'(1);
          end
          if (in_frame_end) begin
            wpeak_nxt = peak_nxt;
            wovf_nxt  = ovf_nxt;
            q_nxt     = sum_nxt;
            dvs_nxt   = 24'(count_nxt);
            rem_nxt   = '0;
            iter_nxt  = '0;
            peak_nxt  = '0;
            sum_nxt   = '0;
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV, S_CDIV: begin
        rem_nxt  = sub_ge ? sub_d[23:0] : sub_a;
        q_nxt    = {q_r[SUM_W-2:0], sub_ge};
        iter_nxt = iter_r + 6'd1;
        if (iter_r == 6'(SUM_W - 1)) begin
          iter_nxt = '0;
          rem_nxt  = '0;
          if (state_r == S_DIV) begin
            root_nxt  = '0;
            state_nxt = S_SQRT;
          end else begin
            state_nxt = S_LOG;
          end
        end
      end
      S_SQRT: begin
        rem_nxt  = sub_ge ? sub_d[23:0] : sub_a;
        q_nxt    = {q_r[SUM_W-3:0], 2'b00};
        root_nxt = {root_r[19:0], sub_ge};
        iter_nxt = iter_r + 6'd1;
        if (iter_r == 6'(SUM_W / 2 - 1)) begin
          iter_nxt = '0;
          state_nxt = S_DONE;  // updated below when rms is nonzero
        end
      end
      S_LOG: begin
        if (iter_r == '0 && x_r == '0 && frac_r == '0 && e_r == '0) begin
          // First cycle: normalize the crest ratio to a Q1.30 mantissa.
          e_nxt = e_find;
          x_nxt = 31'(crest_r) << (5'd30 - 5'(e_find));
          e_nxt = e_find;
          iter_nxt = 6'd1;
        end else begin
          frac_nxt = {frac_r[14:0], sq_x[31]};
          x_nxt    = sq_x[31] ? sq_x[31:1] : sq_x[30:0];
          iter_nxt = iter_r + 6'd1;
          if (iter_r == 6'd16) state_nxt = S_DB;
        end
      end
      S_DB: begin
        db_nxt    = 17'(db_round >> 24);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    // Square root finished: branch on the RMS value.
    if (state_r == S_SQRT && iter_r == 6'(SUM_W / 2 - 1)) begin
      rms_nxt = ({root_r[19:0], sub_ge} > 21'(LEVEL_MAX)) ? 16'(LEVEL_MAX) :
                {root_r[14:0], sub_ge};
      if ({root_r[19:0], sub_ge} == '0) begin
        crest_nxt = '0;
        db_nxt    = 17'(DB_FLOOR);
        state_nxt = S_DONE;
      end else begin
        q_nxt     = SUM_W'({wpeak_r, 8'h00});
        dvs_nxt   = 24'(rms_nxt);
        rem_nxt   = '0;
        state_nxt = S_CDIV;
      end
    end
    // Crest ratio finished: below one gives zero dB without the logarithm.
    if (state_r == S_CDIV && iter_r == 6'(SUM_W - 1)) begin
      crest_nxt = ({q_r[SUM_W-2:0], sub_ge} > SUM_W'(CREST_MAX)) ?
                  15'(CREST_MAX) : {q_r[13:0], sub_ge};
      x_nxt    = '0;
      frac_nxt = '0;
      e_nxt    = '0;
      if (crest_nxt < 15'd256) begin
        db_nxt    = '0;
        state_nxt = S_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      peak_r      <= '0;
      sum_r       <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      iter_r      <= '0;
      x_r         <= '0;
      frac_r      <= '0;
      e_r         <= '0;
    end else begin
      state_r <= state_nxt;
      peak_r  <= peak_nxt;
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      iter_r  <= iter_nxt;
      x_r     <= x_nxt;
      frac_r  <= frac_nxt;
      e_r     <= e_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    wpeak_r <= wpeak_nxt;
    wovf_r  <= wovf_nxt;
    q_r     <= q_nxt;
    rem_r   <= rem_nxt;
    dvs_r   <= dvs_nxt;
    root_r  <= root_nxt;
    rms_r   <= rms_nxt;
    crest_r <= crest_nxt;
    db_r    <= db_nxt;
    if (out_load) begin
      o_rms_r   <= rms_r;
      o_peak_r  <= wpeak_r;
      o_crest_r <= crest_r;
      o_db_r    <= db_r;
      o_dens_r  <= (wpeak_r > rms_r) ? (wpeak_r - rms_r) : '0;
      o_ovf_r   <= wovf_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_rms_level         = o_rms_r;
  assign out_peak_level        = o_peak_r;
  assign out_crest_ratio       = o_crest_r;
  assign out_crest_decibels    = o_db_r;
  assign out_transient_density = o_dens_r;
  assign out_overflow          = o_ovf_r;
endmodule

// ----- sv/prcm_checker.sv -----
// Port-level checker bound to every instance of the peak/RMS/crest meter core.
// Depends on prcm_pkg for the dB floor and level limits.
module prcm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [15:0]        out_rms_level,
  input logic [15:0]        out_peak_level,
  input logic [14:0]        out_crest_ratio,
  input logic signed [16:0] out_crest_decibels,
  input logic [15:0]        out_transient_density
);
  import prcm_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rms_level)
      && $stable(out_crest_decibels))
    else $error("result changed while stalled");

  a_zero_rms: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rms_level == 16'd0 |->
      out_crest_ratio == 15'd0 && out_crest_decibels == 17'(DB_FLOOR))
    else $error("zero rms without floored crest");

  a_density: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_transient_density <= out_peak_level
      && out_rms_level <= 16'(LEVEL_MAX))
    else $error("density or rms out of range");

  a_crest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_crest_ratio != 15'd0 && out_crest_ratio < 15'd256 |->
      out_crest_decibels == 17'sd0)
    else $error("crest below one must give zero dB");
endmodule

bind peak_rms_crest_meter_core prcm_checker u_prcm_checker (.*);

// ----- bench/tb.sv -----
// Self-checking bench for peak_rms_crest_meter_core: a directed table of frames,
// a spike frame and random frames, checked against a fixed-point meter predictor
// (typed table rows against fixed reports). Depends on prcm_pkg and the core RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import prcm_pkg::*;

  typedef struct {
    logic [15:0]        rms;
    logic [15:0]        peak;
    logic [14:0]        crest;
    logic signed [16:0] db;
    logic [15:0]        dens;
    logic               ovf;
  } level_report_t;

  typedef struct {
    logic signed [15:0] sample;
    logic               last;
    bit                 typed;
    level_report_t      report;
  } table_row_t;

  localparam longint unsigned SQ_SUM_MAX = (64'd1 << SUM_W) - 1;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_sample = '0;
  logic               in_frame_end = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [15:0]        out_rms_level;
  logic [15:0]        out_peak_level;
  logic [14:0]        out_crest_ratio;
  logic signed [16:0] out_crest_decibels;
  logic [15:0]        out_transient_density;
  logic               out_overflow;

  // Predictor state.
  int unsigned     pk_level;
  longint unsigned sq_sum;
  int unsigned     n_samples;
  bit              long_frame;

  level_report_t reports_due[$];
  int  mismatches;
  int  items_sent;
  int  frames_sent;
  int  clamp_frames;
  int  hold_left;
  bit  no_gaps;

  peak_rms_crest_meter_core u_top (.*);

  always #6 clk = ~clk;

  initial begin
    #20_000_000;
    $display("timeout with %0d reports outstanding", reports_due.size());
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int unsigned floor_sqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return int'(res);
  endfunction

  // log2(q/256) in Q16: exact integer part, fraction by repeated squaring.
  function automatic longint unsigned ratio_log2(int unsigned q);
    int unsigned     e = 0;
    longint unsigned m;
    longint unsigned frac = 0;
    while (e < 31 && (q >> (e + 1)) != 0) e++;
    m = longint'(q) << (30 - e);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac <<= 1;
      if (m >= (64'd2 << 30)) begin
        m >>= 1;
        frac |= 1;
      end
    end
    return (longint'(e - 8) << 16) + frac;
  endfunction

  // Advances the meter state by one sample; returns 1 with a report on frame end.
  function automatic bit meter_step(logic signed [15:0] s, logic last,
                                    output level_report_t r);
    int unsigned     mag = (s < 0) ? int'(-int'(s)) : int'(s);
    int unsigned     rms, crest, dens;
    longint unsigned c;
    int              db;
    if (mag > pk_level) pk_level = mag;
    if (n_samples >= MAX_SAMPLES_DEF) begin
      long_frame = 1;
    end else begin
      sq_sum += longint'(mag) * mag;
      if (sq_sum > SQ_SUM_MAX) sq_sum = SQ_SUM_MAX;
      n_samples++;
    end
    if (!last) return 0;
    rms = floor_sqrt(sq_sum / n_samples);
    if (rms > LEVEL_MAX) rms = LEVEL_MAX;
    if (rms == 0) begin
      crest = 0;
      db = DB_FLOOR;
    end else begin
      c = (longint'(pk_level) << 8) / rms;
      if (c > CREST_MAX) c = CREST_MAX;
      crest = int'(c);
      if (crest < 256) db = 0;
      else db = int'((ratio_log2(crest) * DB_K + (64'd1 << 23)) >> 24);
    end
    dens = (pk_level > rms) ? pk_level - rms : 0;
    if (dens > LEVEL_MAX) dens = LEVEL_MAX;
    r.rms = rms[15:0];
    r.peak = pk_level[15:0];
    r.crest = crest[14:0];
    r.db = db[16:0];
    r.dens = dens[15:0];
    r.ovf = long_frame;
    pk_level = 0;
    sq_sum = 0;
    n_samples = 0;
    long_frame = 0;
    return 1;
  endfunction

  // Offers one sample and waits for its transfer; returns the predicted report.
  task automatic offer_sample(logic signed [15:0] s, logic last,
                              output bit has_report, output level_report_t r);
    if (!no_gaps && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    in_frame_end <= last;
    do @(posedge clk); while (in_stall);
    items_sent++;
    has_report = meter_step(s, last, r);
    if (has_report) frames_sent++;
  endtask

  task automatic send_sample(logic signed [15:0] s, logic last);
    bit            got;
    level_report_t r;
    offer_sample(s, last, got, r);
    if (got) begin
      if (r.crest == 15'(CREST_MAX)) clamp_frames++;
      reports_due.insert(reports_due.size(), r);
    end
  endtask

  // Frame flavors: 0 random, 1 quiet, 2 near full scale, 3 constant.
  task automatic send_frame(int flavor, int len);
    logic signed [15:0] k = 16'($urandom);
    logic signed [15:0] s;
    for (int i = 0; i < len; i++) begin
      case (flavor)
        1:       s = 16'($signed($urandom_range(0, 511)) - 256);
        2:       s = $urandom_range(1) ? 16'sh7fff - 16'($urandom_range(63))
                                       : 16'sh8000 + 16'($urandom_range(63));
        3:       s = k;
        default: s = 16'($urandom);
      endcase
      send_sample(s, i == len - 1);
    end
  endtask

  task automatic check_report(level_report_t got);
    level_report_t want;
    if (reports_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected report: rms %0d peak %0d", got.rms, got.peak);
      return;
    end
    want = reports_due.pop_front();
    if (got.rms !== want.rms || got.peak !== want.peak || got.crest !== want.crest ||
        got.db !== want.db || got.dens !== want.dens || got.ovf !== want.ovf) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch expected rms %0d peak %0d crest %0d db %0d dens %0d ovf %0d",
                 want.rms, want.peak, want.crest, want.db, want.dens, want.ovf);
        $display("         actual   rms %0d peak %0d crest %0d db %0d dens %0d ovf %0d",
                 got.rms, got.peak, got.crest, got.db, got.dens, got.ovf);
      end
    end
  endtask

  // Result side: checks each transfer, then picks the stall for the next cycle.
  initial begin
    level_report_t got;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        got.rms = out_rms_level;
        got.peak = out_peak_level;
        got.crest = out_crest_ratio;
        got.db = out_crest_decibels;
        got.dens = out_transient_density;
        got.ovf = out_overflow;
        check_report(got);
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (no_gaps) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 33);
      end
    end
  end

  initial begin
    table_row_t    rows[13];
    table_row_t    row;
    bit            got;
    level_report_t r;
    int            len;

    pk_level = 0;
    sq_sum = 0;
    n_samples = 0;
    long_frame = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Single-sample frames have obvious answers; a zero frame hits the dB floor.
    rows[0] = '{16'sd0, 1, 1, '{16'd0, 16'd0, 15'd0, -17'sd46080, 16'd0, 1'b0}};
    rows[1] = '{-16'sd32768, 1, 1,
                '{16'd32768, 16'd32768, 15'd256, 17'sd0, 16'd0, 1'b0}};
    rows[2] = '{16'sd32767, 1, 1,
                '{16'd32767, 16'd32767, 15'd256, 17'sd0, 16'd0, 1'b0}};
    rows[3] = '{16'sd1, 1, 1, '{16'd1, 16'd1, 15'd256, 17'sd0, 16'd0, 1'b0}};
    rows[4] = '{16'sd16384, 0, 0, r};
    rows[5] = '{16'sd0, 0, 0, r};
    rows[6] = '{16'sd0, 0, 0, r};
    rows[7] = '{-16'sd16384, 1, 0, r};
    rows[8] = '{-16'sd1, 0, 0, r};
    rows[9] = '{16'sd21000, 1, 0, r};
    rows[10] = '{16'sh5555, 0, 0, r};
    rows[11] = '{-16'sh2aab, 0, 0, r};
    rows[12] = '{16'sd100, 1, 0, r};
    foreach (rows[i]) begin
      row = rows[i];
      offer_sample(row.sample, row.last, got, r);
      if (got) reports_due.insert(reports_due.size(), row.typed ? row.report : r);
    end

    // A small spike in a long frame of zeros leaves an RMS of one, so the crest
    // ratio runs into its clamp.
    no_gaps = 1;
    for (int i = 0; i < 1060; i++) send_sample(i == 500 ? 16'sd65 : 16'sd0, i == 1059);
    no_gaps = 0;

    for (int f = 0; items_sent < 1600; f++) begin
      len = ($urandom_range(99) < 80) ? $urandom_range(1, 12) : $urandom_range(13, 64);
      if (f == 3) hold_left = 500;          // receiver holds off while frames keep coming
      if (f == 8) begin
        in_valid <= 1'b0;
        wait (reports_due.size() == 0);
        @(posedge clk);
      end
      no_gaps = (f >= 12 && f < 22);
      send_frame($urandom_range(3), len);
    end
    in_valid <= 1'b0;

    wait (reports_due.size() == 0);
    repeat (200) @(posedge clk);
    $display("%0d samples in %0d frames sent, %0d frames with the crest ratio clamped",
             items_sent, frames_sent, clamp_frames);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
